FILE: hw/rtl/dnsrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnsrp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QFIXED = 4'd2,
    PH_RNAME  = 4'd3,
    PH_PTR    = 4'd4,
    PH_RFIXED = 4'd5,
    PH_RDATA  = 4'd6,
    PH_DONE   = 4'd7
  } phase_e;

  // Result item kinds
  localparam logic [2:0] KIND_HEADER     = 3'd0;
  localparam logic [2:0] KIND_QUESTION   = 3'd1;
  localparam logic [2:0] KIND_END_OK     = 3'd5;
  localparam logic [2:0] KIND_END_TRUNC  = 3'd6;

  // Header layout
  localparam logic [3:0] HDR_FLAGS_IDX   = 4'd2;
  localparam logic [3:0] HDR_COUNTS_IDX  = 4'd4;
  localparam logic [3:0] HDR_LAST_IDX    = 4'd11;
  localparam logic [3:0] QFIX_LAST_IDX   = 4'd3;
  localparam logic [3:0] RFIX_LAST_IDX   = 4'd9;
  localparam logic [7:0] PTR_MASK        = 8'hC0;

  localparam int unsigned OUT_DATA_W = 168;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] rtype;
    logic [31:0] ttl;
    logic [15:0] dlen;
    logic [31:0] head;
    logic [15:0] qd_cnt;
    logic [15:0] an_cnt;
    logic [15:0] ns_cnt;
    logic [15:0] ar_cnt;
    logic        auth;
    logic        last;
  } result_t;

  // Up to two results produced by one message byte
  typedef struct packed {
    result_t    r1;
    result_t    r0;
    logic [1:0] num;
  } emit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dnsrp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module dnsrp_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           consume_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eom_i,
  output dnsrp_pkg::emit_t    emit_o
);

  localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);

  dnsrp_pkg::phase_e phase_q, phase_d;
  logic [3:0]   idx_q, idx_d;
  logic [CW-1:0] bcnt_q, bcnt_d;
  logic [15:0]  cnt_q [4];
  logic [15:0]  cnt_d [4];
  logic [15:0]  rleft_q, rleft_d;
  logic [7:0]   lleft_q, lleft_d;
  logic [15:0]  type_q, type_d;
  logic [31:0]  ttl_q, ttl_d;
  logic [15:0]  len_q, len_d;
  logic [31:0]  head_q, head_d;
  logic [15:0]  dleft_q, dleft_d;
  logic         auth_q, auth_d;
  logic [1:0]   sec_q, sec_d;

  // First section at or after s with a nonzero count; 4 means none
  function automatic logic [2:0] find_section(input logic [3:0] nz, input logic [2:0] s);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--) begin
      if (nz[i] && (3'(i) >= s)) r = 3'(i);
    end
    return r;
  endfunction

  always_comb begin
    dnsrp_pkg::result_t prs, fin;
    logic       prs_v;
    logic       dropped;
    logic       enter;
    logic [2:0] enter_from;
    logic       name_start;
    logic       item_done;
    logic       fixed_start;
    logic [3:0] hoff;
    logic [3:0] nz;
    logic [2:0] ns;
    logic [15:0] rl_dec;
    logic [15:0] dl_dec;

    phase_d = phase_q; idx_d = idx_q; bcnt_d = bcnt_q;
    cnt_d = cnt_q; rleft_d = rleft_q; lleft_d = lleft_q;
    type_d = type_q; ttl_d = ttl_q; len_d = len_q; head_d = head_q;
    dleft_d = dleft_q; auth_d = auth_q; sec_d = sec_q;
    prs = '0; fin = '0; prs_v = 1'b0; dropped = 1'b0;
    enter = 1'b0; enter_from = 3'd0; name_start = 1'b0;
    item_done = 1'b0; fixed_start = 1'b0;
    hoff = idx_q - dnsrp_pkg::HDR_COUNTS_IDX;
    rl_dec = rleft_q - 16'd1;
    dl_dec = dleft_q - 16'd1;
    emit_o = '0;

    if (consume_i) begin
      if (bcnt_q < CW'(MAX_MESSAGE_BYTES)) begin
        bcnt_d = bcnt_q + CW'(1);
        unique case (phase_q)
          dnsrp_pkg::PH_HEADER: begin
            if (idx_q == dnsrp_pkg::HDR_FLAGS_IDX) auth_d = byte_i[2];
            if (idx_q >= dnsrp_pkg::HDR_COUNTS_IDX) begin
              cnt_d[hoff[2:1]] = {cnt_q[hoff[2:1]][7:0], byte_i};
            end
            idx_d = idx_q + 4'd1;
            if (idx_q == dnsrp_pkg::HDR_LAST_IDX) begin
              prs_v = 1'b1;
              prs.kind = dnsrp_pkg::KIND_HEADER;
              enter = 1'b1;
              enter_from = 3'd0;
            end
          end
          dnsrp_pkg::PH_QNAME, dnsrp_pkg::PH_RNAME: begin
            if (lleft_q != 8'd0) begin
              lleft_d = lleft_q - 8'd1;
            end else if (byte_i == 8'd0) begin
              fixed_start = 1'b1;
            end else if ((byte_i & dnsrp_pkg::PTR_MASK) == dnsrp_pkg::PTR_MASK) begin
              phase_d = dnsrp_pkg::PH_PTR;
            end else begin
              lleft_d = byte_i;
            end
          end
          dnsrp_pkg::PH_PTR: fixed_start = 1'b1;
          dnsrp_pkg::PH_QFIXED: begin
            if (idx_q < 4'd2) type_d = {type_q[7:0], byte_i};
            idx_d = idx_q + 4'd1;
            if (idx_q == dnsrp_pkg::QFIX_LAST_IDX) begin
              prs_v = 1'b1;
              prs.kind = dnsrp_pkg::KIND_QUESTION;
              prs.rtype = type_d;
              item_done = 1'b1;
            end
          end
          dnsrp_pkg::PH_RFIXED: begin
            if (idx_q < 4'd2) type_d = {type_q[7:0], byte_i};
            else if (idx_q >= 4'd4 && idx_q < 4'd8) ttl_d = {ttl_q[23:0], byte_i};
            else if (idx_q >= 4'd8) len_d = {len_q[7:0], byte_i};
            idx_d = idx_q + 4'd1;
            if (idx_q == dnsrp_pkg::RFIX_LAST_IDX) begin
              dleft_d = len_d;
              head_d = '0;
              idx_d = 4'd0;
              if (len_d == 16'd0) begin
                prs_v = 1'b1;
                item_done = 1'b1;
              end else begin
                phase_d = dnsrp_pkg::PH_RDATA;
              end
            end
          end
          dnsrp_pkg::PH_RDATA: begin
            if (idx_q < 4'd4) begin
              case (idx_q[1:0])
                2'd0:    head_d = head_q | {byte_i, 24'd0};
                2'd1:    head_d = head_q | {8'd0, byte_i, 16'd0};
                2'd2:    head_d = head_q | {16'd0, byte_i, 8'd0};
                default: head_d = head_q | {24'd0, byte_i};
              endcase
              idx_d = idx_q + 4'd1;
            end
            dleft_d = dl_dec;
            if (dl_dec == 16'd0) begin
              prs_v = 1'b1;
              item_done = 1'b1;
            end
          end
          dnsrp_pkg::PH_DONE: ;
          default: ;
        endcase

        // Record item: tagged with its section
        if (prs_v && (phase_q == dnsrp_pkg::PH_RFIXED || phase_q == dnsrp_pkg::PH_RDATA)) begin
          prs.kind  = dnsrp_pkg::KIND_QUESTION + {1'b0, sec_q};
          prs.rtype = type_d;
          prs.ttl   = ttl_d;
          prs.dlen  = len_d;
          prs.head  = head_d;
        end
        if (prs_v && phase_q == dnsrp_pkg::PH_HEADER) begin
          prs.qd_cnt = cnt_d[0];
          prs.an_cnt = cnt_d[1];
          prs.ns_cnt = cnt_d[2];
          prs.ar_cnt = cnt_d[3];
          prs.auth   = auth_d;
        end

        // Start of fixed fields after a name
        if (fixed_start) begin
          phase_d = (sec_q == 2'd0) ? dnsrp_pkg::PH_QFIXED : dnsrp_pkg::PH_RFIXED;
          idx_d = 4'd0;
          type_d = '0; ttl_d = '0; len_d = '0; head_d = '0;
        end

        // One question or record finished
        if (item_done) begin
          rleft_d = rl_dec;
          if (rl_dec == 16'd0) begin
            enter = 1'b1;
            enter_from = {1'b0, sec_q} + 3'd1;
          end else begin
            name_start = 1'b1;
          end
        end

        // Move to the next section with records
        if (enter) begin
          for (int i = 0; i < 4; i++) nz[i] = (cnt_d[i] != 16'd0);
          ns = find_section(nz, enter_from);
          if (ns == 3'd4) begin
            phase_d = dnsrp_pkg::PH_DONE;
          end else begin
            sec_d = ns[1:0];
            rleft_d = cnt_d[ns[1:0]];
            name_start = 1'b1;
          end
        end else begin
          nz = '0;
          ns = '0;
        end

        if (name_start) begin
          phase_d = (sec_d == 2'd0) ? dnsrp_pkg::PH_QNAME : dnsrp_pkg::PH_RNAME;
          lleft_d = 8'd0;
          idx_d = 4'd0;
        end
      end else begin
        dropped = 1'b1;
        nz = '0;
        ns = '0;
      end

      // End of message item and return to reset state
      fin.kind = (!dropped && phase_d == dnsrp_pkg::PH_DONE) ?
                 dnsrp_pkg::KIND_END_OK : dnsrp_pkg::KIND_END_TRUNC;
      fin.last = 1'b1;
      if (eom_i) begin
        phase_d = dnsrp_pkg::PH_HEADER; idx_d = '0; bcnt_d = '0;
        for (int i = 0; i < 4; i++) cnt_d[i] = '0;
        rleft_d = '0; lleft_d = '0; type_d = '0; ttl_d = '0; len_d = '0;
        head_d = '0; dleft_d = '0; auth_d = 1'b0; sec_d = '0;
        if (prs_v) begin
          emit_o.r0  = prs;
          emit_o.r1  = fin;
          emit_o.num = 2'd2;
        end else begin
          emit_o.r0  = fin;
          emit_o.num = 2'd1;
        end
      end else if (prs_v) begin
        emit_o.r0 = prs;
        emit_o.r0.last = 1'b1;
        emit_o.num = 2'd1;
      end
    end else begin
      nz = '0;
      ns = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dnsrp_pkg::PH_HEADER;
      idx_q   <= '0;
      bcnt_q  <= '0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      rleft_q <= '0;
      lleft_q <= '0;
      type_q  <= '0;
      ttl_q   <= '0;
      len_q   <= '0;
      head_q  <= '0;
      dleft_q <= '0;
      auth_q  <= 1'b0;
      sec_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      bcnt_q  <= bcnt_d;
      cnt_q   <= cnt_d;
      rleft_q <= rleft_d;
      lleft_q <= lleft_d;
      type_q  <= type_d;
      ttl_q   <= ttl_d;
      len_q   <= len_d;
      head_q  <= head_d;
      dleft_q <= dleft_d;
      auth_q  <= auth_d;
      sec_q   <= sec_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dnsrp_ofifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dnsrp_ofifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dnsrp_pkg::emit_t emit_i,
  input  wire logic          pop_i,
  output dnsrp_pkg::result_t head_o,
  output logic [2:0]         count_o
);

  localparam int unsigned PW = $clog2(dnsrp_pkg::FIFO_DEPTH);

  dnsrp_pkg::result_t mem_q [dnsrp_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [PW-1:0] wr_next;

  assign wr_next = wr_q + PW'(1);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PW'(emit_i.num);
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + {1'b0, emit_i.num} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (emit_i.num != 2'd0) mem_q[wr_q] <= emit_i.r0;
    if (emit_i.num == 2'd2) mem_q[wr_next] <= emit_i.r1;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dns_response_parser_core.sv
// An accepted byte is held in the input register, and its results in the output
// queue, before they reach the master side. Throughput: one message byte per
// cycle; each byte yields at most two result transactions, buffered in a
// 4-entry output queue that stalls input when fewer than two entries are free.
// Reset: rst_ni is asynchronous, active low; it clears the parser state, the
// input register and the output queue.
`timescale 1ns / 1ps
`default_nettype none

module dns_response_parser_core #(
  parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] msg_byte
  input  wire logic         s_axis_tlast_i,   // end_of_message
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [15:0] record_type, [47:16] time_to_live, [63:48] data_length,
  // [95:64] data_head, [111:96] question_count, [127:112] answer_records,
  // [143:128] authority_records, [159:144] additional_records, [160] authoritative
  output logic [dnsrp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [2:0]        m_axis_tuser_o,   // [2:0] item_kind
  output logic              m_axis_tlast_o    // last_of_run
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eom_q;
  logic       consume;
  logic       pop;
  logic [2:0] q_count;
  dnsrp_pkg::emit_t   emit;
  dnsrp_pkg::result_t q_head;

  // Parse a registered byte only when the queue can take two results
  assign consume         = in_vld_q && (q_count <= 3'(dnsrp_pkg::FIFO_DEPTH - 2));
  assign s_axis_tready_o = !in_vld_q || consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eom_q  <= s_axis_tlast_i;
    end
  end

  dnsrp_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .consume_i(consume),
    .byte_i   (in_byte_q),
    .eom_i    (in_eom_q),
    .emit_o   (emit)
  );

  dnsrp_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .pop_i  (pop),
    .head_o (q_head),
    .count_o(q_count)
  );

  // Output stream
  assign m_axis_tvalid_o = (q_count != 3'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tuser_o  = q_head.kind;
  assign m_axis_tlast_o  = q_head.last;
  assign m_axis_tdata_o  = {7'd0, q_head.auth, q_head.ar_cnt, q_head.ns_cnt,
                            q_head.an_cnt, q_head.qd_cnt, q_head.head,
                            q_head.dlen, q_head.ttl, q_head.rtype};

endmodule

`default_nettype wire
